>>> hdl/fupp_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the form pair parser

package fupp_pkg;

   localparam int unsigned MAX_PAIRS  = 255;
   localparam int unsigned NAME_LIMIT = 77;

   localparam logic [7:0] MAX_PAIRS_B  = 8'(MAX_PAIRS);
   localparam logic [6:0] NAME_LIMIT_B = 7'(NAME_LIMIT);

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_SEPARATOR     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_DECODE_VALUES = CSR_INDEX_W'(1);

   localparam logic [7:0] SEPARATOR_RESET = 8'd38;
   localparam logic       DECODE_RESET    = 1'b1;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;

   typedef enum logic [1:0] {
      PH_NAME  = 2'd0,
      PH_VALUE = 2'd1,
      PH_PCT1  = 2'd2,
      PH_PCT2  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NAME_BYTE  = 3'd0,
      KIND_NAME_DONE  = 3'd1,
      KIND_VALUE_BYTE = 3'd2,
      KIND_PAIR_DONE  = 3'd3,
      KIND_DISCARD    = 3'd4,
      KIND_OVERFLOW   = 3'd5
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       new_request;
   } req_word_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic [6:0] held_spaces;
      logic [7:0] pair_index;
      logic       last;
   } rsp_word_type;

   // up to two result words from one step, in order
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type word0;
      rsp_word_type word1;
   } push_type;

   typedef struct packed {
      logic [7:0] separator;
      logic       decode_values;
   } cfg_type;

   // non-hex characters count as zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h61 && c <= 8'h66)
         v = 4'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46)
         v = 4'(c - 8'h37);
      else if (c >= 8'h30 && c <= 8'h39)
         v = 4'(c - 8'h30);
      return v;
   endfunction

endpackage

>>> hdl/fupp_if.sv
`timescale 1ns / 1ps
// handshake channel interfaces for the form pair parser

interface fupp_req_if;
   import fupp_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   logic       new_request;
   modport source (output valid, data_byte, last_byte, new_request, input ready);
   modport sink (input valid, data_byte, last_byte, new_request, output ready);
endinterface

interface fupp_rsp_if;
   import fupp_pkg::*;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] out_byte;
   logic [6:0] held_spaces;
   logic [7:0] pair_index;
   logic       last;
   modport source (output valid, kind, out_byte, held_spaces, pair_index, last,
                   input ready);
   modport sink (input valid, kind, out_byte, held_spaces, pair_index, last,
                 output ready);
endinterface

interface fupp_csr_if;
   import fupp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/fupp_step.sv
`timescale 1ns / 1ps
// per-byte tokenizer state and step logic

module fupp_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  fupp_pkg::req_word_type in_word,
   input  fupp_pkg::cfg_type      cfg,
   output fupp_pkg::push_type     push
);
   import fupp_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic [6:0] name_length_ff, name_length_in;
   logic [6:0] pending_spaces_ff, pending_spaces_in;
   logic       token_nonempty_ff, token_nonempty_in;
   logic       value_cut_ff, value_cut_in;
   logic [7:0] pair_count_ff, pair_count_in;
   logic       overflow_ff, overflow_in;

   // candidate results: byte result, cut escape byte, token end marker
   logic       t_valid;
   kind_type   t_kind;
   logic [7:0] t_byte;
   logic [6:0] t_held;
   logic       e0_valid;
   logic [7:0] e0_byte;
   logic       e1_valid;
   kind_type   e1_kind;
   logic [7:0] idx;

   // next state
   always_comb begin
      phase_type  ph;
      logic [3:0] hn;
      logic [6:0] nl;
      logic [6:0] ps;
      logic       tn;
      logic       vc;
      logic [7:0] pc;
      logic       ov;
      logic       end_req;
      logic [7:0] b;
      logic [7:0] dv;
      logic [7:0] name_sum;

      b        = in_word.data_byte;
      ph       = in_word.new_request ? PH_NAME : phase_ff;
      hn       = in_word.new_request ? 4'd0 : high_nibble_ff;
      nl       = in_word.new_request ? 7'd0 : name_length_ff;
      ps       = in_word.new_request ? 7'd0 : pending_spaces_ff;
      tn       = in_word.new_request ? 1'b0 : token_nonempty_ff;
      vc       = in_word.new_request ? 1'b0 : value_cut_ff;
      pc       = in_word.new_request ? 8'd0 : pair_count_ff;
      ov       = in_word.new_request ? 1'b0 : overflow_ff;
      end_req  = 1'b0;
      dv       = {hn, hex_value(b)};
      name_sum = {1'b0, nl} + {1'b0, ps};

      t_valid  = 1'b0;
      t_kind   = KIND_NAME_BYTE;
      t_byte   = 8'd0;
      t_held   = 7'd0;
      e0_valid = 1'b0;
      e0_byte  = {hn, 4'd0};
      e1_valid = 1'b0;
      e1_kind  = KIND_DISCARD;
      idx      = pc;

      priority if (ov) begin
         ph = PH_NAME; hn = 4'd0; nl = 7'd0; ps = 7'd0; tn = 1'b0; vc = 1'b0;
      end else if (b == cfg.separator) begin
         end_req = 1'b1;
      end else begin
         tn = 1'b1;
         unique case (ph)
            PH_NAME: begin
               priority if (b == CHAR_EQUALS) begin
                  if (pc >= MAX_PAIRS_B) begin
                     t_valid = 1'b1;
                     t_kind  = KIND_OVERFLOW;
                     ov      = 1'b1;
                     ph = PH_NAME; hn = 4'd0; nl = 7'd0; ps = 7'd0;
                     tn = 1'b0; vc = 1'b0;
                  end else begin
                     t_valid = 1'b1;
                     t_kind  = KIND_NAME_DONE;
                     ph      = PH_VALUE;
                     ps      = 7'd0;
                     vc      = 1'b0;
                     hn      = 4'd0;
                  end
               end else if (b == CHAR_SPACE) begin
                  if (nl != 7'd0 && ps < NAME_LIMIT_B)
                     ps = ps + 7'd1;
               end else if (b != 8'd0) begin
                  if (name_sum < {1'b0, NAME_LIMIT_B}) begin
                     t_valid = 1'b1;
                     t_byte  = b;
                     t_held  = ps;
                     nl      = 7'(name_sum + 8'd1);
                  end else if (nl < NAME_LIMIT_B) begin
                     // only part of the held spaces fits: send it as a space
                     t_valid = 1'b1;
                     t_byte  = CHAR_SPACE;
                     t_held  = NAME_LIMIT_B - nl - 7'd1;
                     nl      = NAME_LIMIT_B;
                  end
                  ps = 7'd0;
               end
            end
            PH_VALUE: begin
               if (!vc) begin
                  priority if (cfg.decode_values && b == CHAR_PLUS) begin
                     t_valid = 1'b1;
                     t_kind  = KIND_VALUE_BYTE;
                     t_byte  = CHAR_SPACE;
                  end else if (cfg.decode_values && b == CHAR_PERCENT) begin
                     ph = PH_PCT1;
                  end else if (b == 8'd0) begin
                     vc = 1'b1;
                  end else begin
                     t_valid = 1'b1;
                     t_kind  = KIND_VALUE_BYTE;
                     t_byte  = b;
                  end
               end
            end
            PH_PCT1: begin
               hn = hex_value(b);
               ph = PH_PCT2;
            end
            PH_PCT2: begin
               ph = PH_VALUE;
               if (dv == 8'd0) begin
                  vc = 1'b1;
               end else begin
                  t_valid = 1'b1;
                  t_kind  = KIND_VALUE_BYTE;
                  t_byte  = dv;
               end
               hn = 4'd0;
            end
            default: ph = PH_NAME;
         endcase
         if (!ov && in_word.last_byte)
            end_req = 1'b1;
      end

      if (end_req) begin
         if (ph == PH_NAME) begin
            e1_valid = tn;
            e1_kind  = KIND_DISCARD;
         end else begin
            // escape cut short: missing digits count as zero
            e0_valid = (ph == PH_PCT2) && !vc && (hn != 4'd0);
            e0_byte  = {hn, 4'd0};
            e1_valid = 1'b1;
            e1_kind  = KIND_PAIR_DONE;
            pc       = pc + 8'd1;
         end
         ph = PH_NAME; hn = 4'd0; nl = 7'd0; ps = 7'd0; tn = 1'b0; vc = 1'b0;
      end

      phase_in          = ph;
      high_nibble_in    = hn;
      name_length_in    = nl;
      pending_spaces_in = ps;
      token_nonempty_in = tn;
      value_cut_in      = vc;
      pair_count_in     = pc;
      overflow_in       = ov;
   end

   // result packing, in model order, last flag on the final word
   always_comb begin
      rsp_word_type w_t;
      rsp_word_type w_e0;
      rsp_word_type w_e1;
      w_t  = '{kind: t_kind, out_byte: t_byte, held_spaces: t_held,
               pair_index: idx, last: 1'b0};
      w_e0 = '{kind: KIND_VALUE_BYTE, out_byte: e0_byte, held_spaces: 7'd0,
               pair_index: idx, last: 1'b0};
      w_e1 = '{kind: e1_kind, out_byte: 8'd0, held_spaces: 7'd0,
               pair_index: idx, last: 1'b1};
      push.word0 = w_e1;
      push.word1 = w_e1;
      priority if (t_valid) begin
         push.word0 = w_t;
         if (e0_valid)
            push.word1 = w_e0;
      end else if (e0_valid) begin
         push.word0 = w_e0;
      end
      push.count = step_en ? 2'({1'b0, t_valid} + {1'b0, e0_valid} + {1'b0, e1_valid})
                           : 2'd0;
      if (push.count == 2'd1)
         push.word0.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_NAME;
         high_nibble_ff    <= 4'd0;
         name_length_ff    <= 7'd0;
         pending_spaces_ff <= 7'd0;
         token_nonempty_ff <= 1'b0;
         value_cut_ff      <= 1'b0;
         pair_count_ff     <= 8'd0;
         overflow_ff       <= 1'b0;
      end else if (step_en) begin
         phase_ff          <= phase_in;
         high_nibble_ff    <= high_nibble_in;
         name_length_ff    <= name_length_in;
         pending_spaces_ff <= pending_spaces_in;
         token_nonempty_ff <= token_nonempty_in;
         value_cut_ff      <= value_cut_in;
         pair_count_ff     <= pair_count_in;
         overflow_ff       <= overflow_in;
      end
   end

endmodule

>>> hdl/fupp_rsp_queue.sv
`timescale 1ns / 1ps
// three-word result queue: takes up to two words a cycle, gives one while the receiver is ready

module fupp_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  fupp_pkg::push_type push,
   output logic               space_ok,
   fupp_rsp_if.source         rsp_chan
);
   import fupp_pkg::*;

   localparam int unsigned DEPTH = 3;

   rsp_word_type q_ff [DEPTH];
   rsp_word_type q_in [DEPTH];
   logic [1:0]   count_ff, count_in;
   logic         pop;
   logic [1:0]   base;

   assign pop      = (count_ff != 2'd0) && rsp_chan.ready;
   assign base     = count_ff - {1'b0, pop};
   assign space_ok = count_ff <= 2'd1;
   assign count_in = base + push.count;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (pop && i < DEPTH - 1)
            q_in[i] = q_ff[(i + 1) % DEPTH];
         else
            q_in[i] = q_ff[i];
         if (push.count != 2'd0 && base == 2'(i))
            q_in[i] = push.word0;
         if (push.count == 2'd2 && (base + 2'd1) == 2'(i))
            q_in[i] = push.word1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         count_ff <= 2'd0;
      else
         count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign rsp_chan.valid       = count_ff != 2'd0;
   assign rsp_chan.kind        = q_ff[0].kind;
   assign rsp_chan.out_byte    = q_ff[0].out_byte;
   assign rsp_chan.held_spaces = q_ff[0].held_spaces;
   assign rsp_chan.pair_index  = q_ff[0].pair_index;
   assign rsp_chan.last        = q_ff[0].last;

endmodule

>>> hdl/form_urlencoded_pair_parser.sv
`timescale 1ns / 1ps
// top level of the form, query and cookie pair parser
//
// req_chan takes one byte of the source string per word, with last_byte on
//    the byte that ends the string and new_request to clear the pair count
//    and sticky overflow before that byte
// rsp_chan gives the result words: name bytes, name done, value bytes, pair
//    done, token discarded, overflow; last marks the final word of each byte
// csr_chan writes the separator (index 0) and decode_values (index 1); write
//    only while no byte is in flight, the channel is always ready
// a byte is registered in the input register on entry, then stepped through
//    the tokenizer into the result queue, whose head word drives rsp_chan
// one byte per cycle is sustained while the queue has room; a byte giving
//    two words takes two queue entries, so throughput is then set by the
//    one-word-a-cycle result port
// the result queue holds three words; the step stalls once it holds two,
//    and req_chan.ready drops only when the input register cannot move on
// a receiver stall therefore back-pressures through the queue to req_chan
//    without losing or repeating words
// synchronous reset empties both stages, clears the tokenizer state and
//    sets the registers to separator '&' and decoding on

module form_urlencoded_pair_parser (
   input  logic      clock,
   input  logic      reset,
   fupp_req_if.sink  req_chan,
   fupp_rsp_if.source rsp_chan,
   fupp_csr_if.sink  csr_chan
);
   import fupp_pkg::*;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         req_take;

   // control between stages
   logic         step_en;
   logic         space_ok;
   push_type     push;

   // configuration
   cfg_type      cfg_ff, cfg_in;

   assign step_en        = in_valid_ff && space_ok;
   assign req_chan.ready = !in_valid_ff || step_en;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_take || (in_valid_ff && !step_en);

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
   end

   // payload register, loaded on every accepted word
   always_ff @(posedge clock) begin
      if (req_take)
         in_word_ff <= '{data_byte: req_chan.data_byte,
                         last_byte: req_chan.last_byte,
                         new_request: req_chan.new_request};
   end

   // register writes; unknown indexes are ignored
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_SEPARATOR:     cfg_in.separator     = csr_chan.data[7:0];
            REG_DECODE_VALUES: cfg_in.decode_values = csr_chan.data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         cfg_ff <= '{separator: SEPARATOR_RESET, decode_values: DECODE_RESET};
      else
         cfg_ff <= cfg_in;
   end

   fupp_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .in_word (in_word_ff),
      .cfg     (cfg_ff),
      .push    (push)
   );

   fupp_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_chan (rsp_chan)
   );

`ifndef ASSERT_OFF
   // a byte giving two words flags only the second as its last
   a_two_word_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.word0.last && push.word1.last)
      else $error("two-word step with wrong last flags");

   // a single word from a step is always flagged last
   a_one_word_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd1 |-> push.word0.last)
      else $error("one-word step not flagged last");

   // nothing is pushed unless a byte is stepped
   a_push_needs_step: assert property (@(posedge clock) disable iff (reset)
      !step_en |-> push.count == 2'd0)
      else $error("result pushed without a step");

   // the queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");
`endif

endmodule

>>> test/form_urlencoded_pair_parser_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the form pair parser: directed words, then random requests

module form_urlencoded_pair_parser_tb;
   import fupp_pkg::*;

   localparam int DIRECTED_COUNT = 24;
   localparam int RANDOM_ITEMS   = 1376;
   localparam int PHASE_COUNT    = 9;
   localparam int IDLE_LIMIT     = 2000;
   localparam int FROM_MODEL     = -1;    // row checked against the predictor
   localparam int PRINT_LIMIT    = 40;

   localparam rsp_word_type NO_WORD = '0;

   // one directed row: the request word and, where it is obvious, the words it gives
   typedef struct {
      logic [7:0]   data_byte;
      logic         last_byte;
      logic         new_request;
      int           typed_count;
      rsp_word_type first_word;
      rsp_word_type second_word;
   } directed_row_type;

   // one random request word, with an optional drain and register change before it
   typedef struct {
      req_word_type word;
      bit           drain;
      bit           set_cfg;
      logic [7:0]   sep;
      bit           dec;
      bit           quiet;
   } stim_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fupp_req_if req_bus ();
   fupp_rsp_if rsp_bus ();
   fupp_csr_if csr_bus ();

   form_urlencoded_pair_parser uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // after reset: separator '&', decoding on
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{8'h26, 1'b0, 1'b1, 0, NO_WORD, NO_WORD},                          // empty token
      '{8'h20, 1'b0, 1'b0, 0, NO_WORD, NO_WORD},                          // leading space dropped
      '{8'h61, 1'b0, 1'b0, 1, '{KIND_NAME_BYTE, 8'h61, 7'd0, 8'd0, 1'b1}, NO_WORD},
      '{8'h20, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},                 // inner space held
      '{8'h62, 1'b0, 1'b0, 1, '{KIND_NAME_BYTE, 8'h62, 7'd1, 8'd0, 1'b1}, NO_WORD},
      '{8'h3D, 1'b0, 1'b0, 1, '{KIND_NAME_DONE, 8'h00, 7'd0, 8'd0, 1'b1}, NO_WORD},
      '{8'h2B, 1'b0, 1'b0, 1, '{KIND_VALUE_BYTE, 8'h20, 7'd0, 8'd0, 1'b1}, NO_WORD},
      '{8'h25, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},                 // %41
      '{8'h34, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},
      '{8'h31, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},
      '{8'h25, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},                 // %Fz, non-hex as 0
      '{8'h46, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},
      '{8'h7A, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},
      '{8'h25, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},                 // escape cut by the end
      '{8'h37, 1'b1, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},
      '{8'h78, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},                 // token with no '='
      '{8'h26, 1'b0, 1'b0, 1, '{KIND_DISCARD, 8'h00, 7'd0, 8'd1, 1'b1}, NO_WORD},
      '{8'h00, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},                 // zero in a name
      '{8'h3D, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},
      '{8'h00, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},                 // zero ends the value
      '{8'h71, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},
      '{8'h26, 1'b0, 1'b0, FROM_MODEL, NO_WORD, NO_WORD},
      '{8'h3D, 1'b0, 1'b1, 1, '{KIND_NAME_DONE, 8'h00, 7'd0, 8'd0, 1'b1}, NO_WORD},
      '{8'hFF, 1'b1, 1'b0, 2, '{KIND_VALUE_BYTE, 8'hFF, 7'd0, 8'd0, 1'b0},
                              '{KIND_PAIR_DONE, 8'h00, 7'd0, 8'd0, 1'b1}}
   };

   // register settings walked by the random part, extremes included
   logic [7:0] phase_sep [PHASE_COUNT] = '{8'd38, 8'd59, 8'd59, 8'd38, 8'd0, 8'd255,
                                          8'd61, 8'd32, 8'd38};
   bit         phase_dec [PHASE_COUNT] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
                                          1'b1, 1'b0, 1'b1};

   // predictor copy of the parser state and registers
   logic [7:0] sep_cfg          = SEPARATOR_RESET;
   logic       decode_cfg       = DECODE_RESET;
   phase_type  tok_phase        = PH_NAME;
   logic [3:0] tok_high_nibble  = '0;
   logic [6:0] tok_name_len     = '0;
   logic [6:0] tok_spaces       = '0;
   logic       tok_seen         = 1'b0;
   logic       tok_value_cut    = 1'b0;
   logic [7:0] pair_total       = '0;
   logic       overflow_seen    = 1'b0;

   rsp_word_type  parse_words [$];   // words of the byte being parsed
   rsp_word_type  words_due [$];     // words still to come out of the block
   stim_item_type stim_items [$];

   int error_count    = 0;
   int accepted_count = 0;
   int idle_cycles    = 0;
   int stall_left     = 0;
   bit no_idle        = 1'b0;

   // generator state while the random part is built
   logic [7:0] gen_sep     = SEPARATOR_RESET;
   bit         gen_dec     = DECODE_RESET;
   bit         gen_quiet   = 1'b0;
   bit         gen_plain   = 1'b0;
   bit         cfg_pending = 1'b0;

   // ---------------------------------------------------------------- predictor

   function automatic logic [3:0] hex_digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      return 4'd0;
   endfunction

   function automatic void emit_word(input kind_type k, input logic [7:0] b,
                                     input logic [6:0] held);
      rsp_word_type w;
      w.kind        = k;
      w.out_byte    = b;
      w.held_spaces = held;
      w.pair_index  = pair_total;
      w.last        = 1'b0;
      parse_words.push_back(w);
   endfunction

   function automatic void clear_token();
      tok_phase       = PH_NAME;
      tok_high_nibble = '0;
      tok_name_len    = '0;
      tok_spaces      = '0;
      tok_seen        = 1'b0;
      tok_value_cut   = 1'b0;
   endfunction

   // a zero value byte stops the rest of the value
   function automatic void value_char(input logic [7:0] v);
      if (v == 8'h00) tok_value_cut = 1'b1;
      else emit_word(KIND_VALUE_BYTE, v, 7'd0);
   endfunction

   function automatic void close_token();
      if (tok_phase == PH_NAME) begin
         if (tok_seen) emit_word(KIND_DISCARD, 8'h00, 7'd0);
      end else begin
         // half-finished escape: missing digits read as zero
         if (tok_phase == PH_PCT2 && !tok_value_cut && tok_high_nibble != 4'd0)
            emit_word(KIND_VALUE_BYTE, {tok_high_nibble, 4'h0}, 7'd0);
         emit_word(KIND_PAIR_DONE, 8'h00, 7'd0);
         pair_total = pair_total + 8'd1;
      end
      clear_token();
   endfunction

   function automatic void name_char(input logic [7:0] c);
      if (int'(tok_name_len) + int'(tok_spaces) < int'(NAME_LIMIT)) begin
         emit_word(KIND_NAME_BYTE, c, tok_spaces);
         tok_name_len = tok_name_len + tok_spaces + 7'd1;
      end else if (tok_name_len < NAME_LIMIT_B) begin
         // held spaces run into the cut: send the part that still fits
         emit_word(KIND_NAME_BYTE, CHAR_SPACE, NAME_LIMIT_B - tok_name_len - 7'd1);
         tok_name_len = NAME_LIMIT_B;
      end
      tok_spaces = '0;
   endfunction

   function automatic void take_char(input logic [7:0] c);
      case (tok_phase)
         PH_NAME: begin
            if (c == CHAR_EQUALS) begin
               if (pair_total >= MAX_PAIRS_B) begin
                  emit_word(KIND_OVERFLOW, 8'h00, 7'd0);
                  overflow_seen = 1'b1;
                  clear_token();
               end else begin
                  emit_word(KIND_NAME_DONE, 8'h00, 7'd0);
                  tok_phase       = PH_VALUE;
                  tok_spaces      = '0;
                  tok_value_cut   = 1'b0;
                  tok_high_nibble = '0;
               end
            end else if (c == CHAR_SPACE) begin
               if (tok_name_len != 7'd0 && tok_spaces < NAME_LIMIT_B)
                  tok_spaces = tok_spaces + 7'd1;
            end else if (c != 8'h00) begin
               name_char(c);
            end
         end
         PH_VALUE: begin
            if (!tok_value_cut) begin
               if (decode_cfg && c == CHAR_PLUS) emit_word(KIND_VALUE_BYTE, CHAR_SPACE, 7'd0);
               else if (decode_cfg && c == CHAR_PERCENT) tok_phase = PH_PCT1;
               else value_char(c);
            end
         end
         PH_PCT1: begin
            tok_high_nibble = hex_digit_value(c);
            tok_phase       = PH_PCT2;
         end
         default: begin
            tok_phase = PH_VALUE;
            value_char({tok_high_nibble, hex_digit_value(c)});
            tok_high_nibble = '0;
         end
      endcase
   endfunction

   // words that one accepted request word gives, into parse_words
   function automatic void parse_byte(input req_word_type w);
      rsp_word_type tail;
      parse_words.delete();
      if (w.new_request) begin
         pair_total    = '0;
         overflow_seen = 1'b0;
         clear_token();
      end
      if (overflow_seen) begin
         clear_token();
      end else begin
         if (w.data_byte == sep_cfg) begin
            close_token();
         end else begin
            tok_seen = 1'b1;
            take_char(w.data_byte);
            if (!overflow_seen && w.last_byte) close_token();
         end
         if (parse_words.size() > 0) begin
            tail      = parse_words[parse_words.size() - 1];
            tail.last = 1'b1;
            parse_words[parse_words.size() - 1] = tail;
         end
      end
   endfunction

   // ---------------------------------------------------------------- stimulus build

   function automatic void push_byte(input logic [7:0] c, input bit last_b = 1'b0);
      stim_item_type s;
      int            pick;
      s.word             = '0;
      s.word.data_byte   = c;
      s.word.last_byte   = last_b;
      s.drain            = 1'b0;
      s.set_cfg          = cfg_pending;
      s.quiet            = gen_quiet;
      cfg_pending        = 1'b0;
      pick = $urandom_range(0, 299);
      if (!gen_plain) begin
         if (pick == 0) begin
            // decoding flipped mid-stream, escapes already begun run to the end
            s.set_cfg = 1'b1;
            gen_dec   = !gen_dec;
         end else if (pick == 1) begin
            s.drain = 1'b1;
         end else if (pick < 8) begin
            s.word.last_byte = 1'b1;
         end else if (pick == 8) begin
            s.word.new_request = 1'b1;
         end
      end
      s.sep = gen_sep;
      s.dec = gen_dec;
      stim_items.push_back(s);
   endfunction

   function automatic logic [7:0] plain_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 8'($urandom_range(97, 122));
      if (pick < 85) return 8'($urandom_range(65, 90));
      return 8'($urandom_range(48, 57));
   endfunction

   function automatic logic [7:0] hex_char_pick();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 8'($urandom_range(48, 57));
      if (pick < 60) return 8'($urandom_range(97, 102));
      if (pick < 80) return 8'($urandom_range(65, 70));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void gen_name();
      int goal;
      int count;
      int n;
      int pick;
      count = 0;
      if ($urandom_range(0, 11) == 0) begin
         // long name with space runs, past the cut
         goal = $urandom_range(70, 110);
         while (count < goal) begin
            n = $urandom_range(1, 20);
            repeat (n) push_byte(plain_char());
            count += n;
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 85) : $urandom_range(0, 3);
            repeat (n) push_byte(CHAR_SPACE);
            count += n;
         end
      end else begin
         n = $urandom_range(0, 8);
         repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) push_byte(CHAR_SPACE);
            else if (pick < 90) push_byte(plain_char());
            else if (pick < 93) push_byte(8'h00);
            else push_byte(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   function automatic void gen_value();
      int n;
      int pick;
      n = $urandom_range(0, 10);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            push_byte(plain_char());
         end else if (pick < 62) begin
            push_byte(CHAR_PLUS);
         end else if (pick < 80) begin
            push_byte(CHAR_PERCENT);
            push_byte(hex_char_pick());
            push_byte(hex_char_pick());
         end else if (pick < 83) begin
            push_byte(8'h00);
         end else begin
            push_byte(8'($urandom_range(0, 255)));
         end
      end
      // escape cut short by the token end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         push_byte(CHAR_PERCENT);
      end else if (pick == 1) begin
         push_byte(CHAR_PERCENT);
         push_byte(hex_char_pick());
      end
   endfunction

   function automatic void gen_token();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      end else begin
         gen_name();
         if (pick < 88) begin
            push_byte(CHAR_EQUALS);
            gen_value();
         end
      end
   endfunction

   function automatic void mark_request(input int first, input bit fresh);
      stim_item_type s;
      s = stim_items[first];
      s.word.new_request = s.word.new_request | fresh;
      stim_items[first] = s;
      s = stim_items[stim_items.size() - 1];
      s.word.last_byte = 1'b1;
      stim_items[stim_items.size() - 1] = s;
   endfunction

   function automatic void gen_request(input bit fresh);
      int first;
      int tokens;
      first  = stim_items.size();
      tokens = $urandom_range(1, 5);
      for (int k = 0; k < tokens; k++) begin
         if ($urandom_range(0, 99) < 8) push_byte(gen_sep);
         gen_token();
         if (k < tokens - 1 || $urandom_range(0, 1) == 1) push_byte(gen_sep);
      end
      if (stim_items.size() == first) push_byte(gen_sep);
      mark_request(first, fresh);
   endfunction

   // 255 pairs of a bare '=' each, then a name and '=' that overflow, then ignored bytes
   function automatic void gen_overflow_request();
      int first;
      gen_plain = 1'b1;
      first = stim_items.size();
      repeat (255) push_byte(CHAR_EQUALS, 1'b1);
      push_byte("a");
      push_byte("b");
      push_byte(CHAR_EQUALS);
      push_byte("c");
      push_byte(CHAR_EQUALS);
      push_byte(gen_sep);
      push_byte("d");
      mark_request(first, 1'b1);
      gen_plain = 1'b0;
   endfunction

   function automatic void build_stimulus();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         gen_sep     = phase_sep[p];
         gen_dec     = phase_dec[p];
         gen_quiet   = (p == 2 || p == 6);
         cfg_pending = 1'b1;
         if (p == 0) begin
            gen_overflow_request();
            gen_request(1'b1);
         end
         while (stim_items.size() < (p + 1) * RANDOM_ITEMS / PHASE_COUNT)
            gen_request($urandom_range(0, 4) != 0);
      end
   endfunction

   // ---------------------------------------------------------------- driving

   function automatic int pick_gap();
      int pick;
      if (no_idle) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= w.data_byte;
      req_bus.last_byte   <= w.last_byte;
      req_bus.new_request <= w.new_request;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // leaves valid high so back-to-back writes need no second assignment
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == REG_SEPARATOR) sep_cfg = val;
      else decode_cfg = val[0];
      @(negedge clock);
   endtask

   // every due word out, then room for a byte that gives no word to pass the step
   task automatic wait_drained();
      while (words_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic flag_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string field, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %02h expected %02h", field, got, want));
   endtask

   // ---------------------------------------------------------------- monitors

   // predict on every accepted request word
   always @(posedge clock) begin
      req_word_type got;
      if (!reset && req_bus.valid && req_bus.ready) begin
         got.data_byte   = req_bus.data_byte;
         got.last_byte   = req_bus.last_byte;
         got.new_request = req_bus.new_request;
         parse_byte(got);
         if (accepted_count < DIRECTED_COUNT &&
             directed_rows[accepted_count].typed_count != FROM_MODEL) begin
            if (directed_rows[accepted_count].typed_count > 0)
               words_due.push_back(directed_rows[accepted_count].first_word);
            if (directed_rows[accepted_count].typed_count > 1)
               words_due.push_back(directed_rows[accepted_count].second_word);
         end else begin
            foreach (parse_words[k]) words_due.push_back(parse_words[k]);
         end
         accepted_count++;
      end
   end

   // compare each result word with the oldest one due
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (words_due.size() == 0) begin
            flag_mismatch($sformatf("word with nothing due, kind %0d byte %02h",
                                    rsp_bus.kind, rsp_bus.out_byte));
         end else begin
            want = words_due.pop_front();
            check_field("kind", 8'(rsp_bus.kind), 8'(want.kind));
            check_field("out_byte", rsp_bus.out_byte, want.out_byte);
            check_field("held_spaces", 8'(rsp_bus.held_spaces), 8'(want.held_spaces));
            check_field("pair_index", rsp_bus.pair_index, want.pair_index);
            check_field("last", 8'(rsp_bus.last), 8'(want.last));
         end
      end
   end

   // receiver stalls: mostly short, now and then long, none in quiet phases
   always @(negedge clock) begin
      int pick;
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (no_idle) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            stall_left = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else if (pick < 10) begin
            stall_left = $urandom_range(10, 40);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // no handshake of any kind for too long ends the run
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("form_urlencoded_pair_parser_tb failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      req_word_type  w;
      stim_item_type item;

      req_bus.valid       = 1'b0;
      req_bus.data_byte   = '0;
      req_bus.last_byte   = 1'b0;
      req_bus.new_request = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;

      build_stimulus();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed part on the reset register values
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         w.data_byte   = directed_rows[i].data_byte;
         w.last_byte   = directed_rows[i].last_byte;
         w.new_request = directed_rows[i].new_request;
         send_word(w);
      end

      // random part; registers only change once the block has gone quiet
      foreach (stim_items[i]) begin
         item = stim_items[i];
         if (item.drain || item.set_cfg) begin
            req_bus.valid <= 1'b0;
            wait_drained();
            if (item.set_cfg) begin
               no_idle = item.quiet;
               write_register(REG_SEPARATOR, item.sep);
               write_register(REG_DECODE_VALUES, CSR_DATA_W'(item.dec));
               csr_bus.valid <= 1'b0;
            end
         end
         send_word(item.word);
      end
      req_bus.valid <= 1'b0;

      wait_drained();
      repeat (6) @(negedge clock);
      if (error_count == 0)
         $display("form_urlencoded_pair_parser_tb passed");
      else
         $display("form_urlencoded_pair_parser_tb failed");
      $finish;
   end

endmodule

>>> sim.f
hdl/fupp_pkg.sv
hdl/fupp_if.sv
hdl/fupp_step.sv
hdl/fupp_rsp_queue.sv
hdl/form_urlencoded_pair_parser.sv
test/form_urlencoded_pair_parser_tb.sv
